@@ rtl/mp2d_pkg.sv @@
// Package for the streaming 2-D max pooling core.
// Holds the register map, field widths, reset values and the clamp helpers.
// No dependencies.
package mp2d_pkg;

	// Default sizes of the line store and of a sample.
	localparam int MAX_COLS_DEF    = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths.
	localparam int POOL_W    = 5;
	localparam int DIM_W     = 11;
	localparam int FLOOR_W   = 16;
	localparam int COL_W     = 10;
	localparam int WIN_W     = 4;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POOL_ROWS  = 3'd0,
		CFG_POOL_COLS  = 3'd1,
		CFG_IMAGE_COLS = 3'd2,
		CFG_IMAGE_ROWS = 3'd3,
		CFG_FLOOR      = 3'd4
	} cfg_idx_t;

	// Register reset values.
	localparam logic [POOL_W-1:0] POOL_RST = 5'd2;
	localparam logic [DIM_W-1:0]  DIM_RST  = 11'd16;

	// Limits of the size registers.
	localparam logic [POOL_W-1:0] POOL_MAX = 5'd16;
	localparam logic [DIM_W-1:0]  DIM_MAX  = 11'd1024;

	// Side information of one finished window row segment.
	typedef struct packed {
		logic             first_row;
		logic             row_end;
		logic             last;
		logic [COL_W-1:0] col;
	} seg_t;

	// Saturate a pool size to 1..16.
	function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_W-1:0] v);
		logic [POOL_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = 5'd1;
		end else if (v > POOL_MAX) begin
			r = POOL_MAX;
		end
		return r;
	endfunction

	// Saturate an image size to 1..1024.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = 11'd1;
		end else if (v > DIM_MAX) begin
			r = DIM_MAX;
		end
		return r;
	endfunction

endpackage

@@ rtl/mp2d_line_mem.sv @@
// Line store of partial window maxima: one write port, one read port.
// Synchronous read; no reset. Uses no package.
module mp2d_line_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; a read of the address being written returns the old data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/mp2d_ctrl.sv @@
// Window and region counters and the running maximum of the current row segment.
// Issues one finished segment per window row; depends on mp2d_pkg.
module mp2d_ctrl
	import mp2d_pkg::*;
#(
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IDX_W      = $clog2(MAX_COLS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic [POOL_W-1:0]             pool_rows,
	input  logic [POOL_W-1:0]             pool_cols,
	input  logic [DIM_W-1:0]              image_cols,
	input  logic [DIM_W-1:0]              image_rows,
	output logic                          seg_valid,
	output seg_t                          seg,
	output logic [IDX_W-1:0]              seg_idx,
	output logic signed [SAMPLE_BITS-1:0] seg_max
);

	logic [WIN_W-1:0]              ciw_q;
	logic [WIN_W-1:0]              riw_q;
	logic [COL_W-1:0]              col_q;
	logic [COL_W-1:0]              row_q;
	logic [IDX_W-1:0]              idx_q;
	logic signed [SAMPLE_BITS-1:0] rrm_q;

	logic                          seg_done;
	logic                          row_end;
	logic                          col_last;
	logic                          row_last;
	logic [15:0]                   col_span;
	logic [15:0]                   row_span;
	logic signed [SAMPLE_BITS-1:0] rrm_next;

	// End conditions. A region column is last when the next window would not fit,
	// which also catches counters left beyond a new, smaller end.
	always_comb begin
		seg_done = (5'({1'b0, ciw_q}) + 5'd1) >= pool_cols;
		row_end  = (5'({1'b0, riw_q}) + 5'd1) >= pool_rows;
		col_span = 16'({1'b0, col_q} + 11'd2) * 16'(pool_cols);
		row_span = 16'({1'b0, row_q} + 11'd2) * 16'(pool_rows);
		col_last = 16'(image_cols) < col_span;
		row_last = 16'(image_rows) < row_span;
		rrm_next = (ciw_q == '0 || sample_value > rrm_q) ? sample_value : rrm_q;
	end

	// Segment handed to the merge stage.
	always_comb begin
		seg_valid     = accept && seg_done;
		seg.first_row = (riw_q == '0);
		seg.row_end   = row_end;
		seg.last      = col_last && row_last;
		seg.col       = col_q;
		seg_idx       = idx_q;
		seg_max       = rrm_next;
	end

	// Counter and running maximum update on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ciw_q <= '0;
			riw_q <= '0;
			col_q <= '0;
			row_q <= '0;
			idx_q <= '0;
			rrm_q <= '0;
		end else if (accept) begin
			rrm_q <= rrm_next;
			if (seg_done) begin
				ciw_q <= '0;
				if (col_last) begin
					col_q <= '0;
					idx_q <= '0;
					if (row_end) begin
						riw_q <= '0;
						row_q <= row_last ? '0 : row_q + 1'b1;
					end else begin
						riw_q <= riw_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
					idx_q <= (idx_q == IDX_W'(MAX_COLS - 1)) ? '0 : idx_q + 1'b1;
				end
			end else begin
				ciw_q <= ciw_q + 1'b1;
			end
		end
	end

	// The line index wraps before the store depth even when it is not a power of two.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(idx_q) < MAX_COLS)
		else $error("line index beyond store depth");

endmodule

@@ rtl/max_pool_2d_stream_core.sv @@
// Streaming non-overlapping 2-D max pooling core with a configurable floor.
// Throughput: one sample beat per cycle while the merge stage is not held,
// set by one line store access per beat. After a window's last sample beat,
// a pooled beat takes the line store read, then the merge into the output register.
// Reset clears counters, valid flags and configuration registers to their defaults
// at once; the line store is not cleared and needs no clearing pass.
module max_pool_2d_stream_core
	import mp2d_pkg::*;
#(
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_write_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	// Sample channel.
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	// Pooled channel.
	output logic                          pooled_valid,
	input  logic                          pooled_stall,
	output logic signed [SAMPLE_BITS-1:0] pooled_value,
	output logic [COL_W-1:0]              region_col,
	output logic                          last_of_image
);

	localparam int IDX_W = $clog2(MAX_COLS);
	localparam int ACC_W = (SAMPLE_BITS > FLOOR_W) ? SAMPLE_BITS : FLOOR_W;
	localparam logic [63:0] FLOOR_FULL =
		64'd0 - ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic [FLOOR_W-1:0] FLOOR_RST = FLOOR_FULL[FLOOR_W-1:0];

	logic [POOL_W-1:0]             pool_rows_q;
	logic [POOL_W-1:0]             pool_cols_q;
	logic [DIM_W-1:0]              image_cols_q;
	logic [DIM_W-1:0]              image_rows_q;
	logic signed [FLOOR_W-1:0]     floor_q;

	logic                          accept;
	logic                          seg_valid;
	seg_t                          seg;
	logic [IDX_W-1:0]              seg_idx;
	logic signed [SAMPLE_BITS-1:0] seg_max;

	logic                          valid_s1;
	seg_t                          seg_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic signed [SAMPLE_BITS-1:0] max_s1;
	logic                          fwd_s1;
	logic                          s1_go;
	logic [ACC_W-1:0]              rd_data;
	logic signed [ACC_W-1:0]       wr_last_q;
	logic signed [ACC_W-1:0]       base;
	logic signed [ACC_W-1:0]       acc0;
	logic signed [ACC_W-1:0]       acc;

	// Configuration registers; sizes are saturated as they are written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_rows_q  <= POOL_RST;
			pool_cols_q  <= POOL_RST;
			image_cols_q <= DIM_RST;
			image_rows_q <= DIM_RST;
			floor_q      <= FLOOR_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_POOL_ROWS:  pool_rows_q  <= clamp_pool(cfg_data[POOL_W-1:0]);
				CFG_POOL_COLS:  pool_cols_q  <= clamp_pool(cfg_data[POOL_W-1:0]);
				CFG_IMAGE_COLS: image_cols_q <= clamp_dim(cfg_data[DIM_W-1:0]);
				CFG_IMAGE_ROWS: image_rows_q <= clamp_dim(cfg_data[DIM_W-1:0]);
				CFG_FLOOR:      floor_q      <= cfg_data[FLOOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the merge stage moves unless it holds a result for a stalled output.
	assign s1_go        = valid_s1 && !(seg_s1.row_end && pooled_valid && pooled_stall);
	assign sample_stall = valid_s1 && !s1_go;
	assign accept       = sample_valid && !sample_stall;

	mp2d_ctrl #(
		.MAX_COLS    (MAX_COLS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sample_value (sample_value),
		.pool_rows    (pool_rows_q),
		.pool_cols    (pool_cols_q),
		.image_cols   (image_cols_q),
		.image_rows   (image_rows_q),
		.seg_valid    (seg_valid),
		.seg          (seg),
		.seg_idx      (seg_idx),
		.seg_max      (seg_max)
	);

	mp2d_line_mem #(
		.DEPTH (MAX_COLS),
		.WIDTH (ACC_W)
	) u_line (
		.clk     (clk),
		.rd_en   (seg_valid),
		.rd_addr (seg_idx),
		.rd_data (rd_data),
		.wr_en   (s1_go),
		.wr_addr (idx_s1),
		.wr_data (acc)
	);

	// Merge stage register; a read of the entry being written at the same edge
	// takes the written value instead of the store's old data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seg_valid) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seg_valid) begin
			seg_s1 <= seg;
			idx_s1 <= seg_idx;
			max_s1 <= seg_max;
			fwd_s1 <= s1_go && (idx_s1 == seg_idx);
		end
		if (s1_go) begin
			wr_last_q <= acc;
		end
	end

	// Window maximum: segment maximum against the floor on the first row, else the stored partial maximum.
	always_comb begin
		base = fwd_s1 ? wr_last_q : $signed(rd_data);
		acc0 = seg_s1.first_row ? ACC_W'(floor_q) : base;
		acc  = (ACC_W'(max_s1) > acc0) ? ACC_W'(max_s1) : acc0;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pooled_valid <= 1'b0;
		end else if (s1_go && seg_s1.row_end) begin
			pooled_valid <= 1'b1;
		end else if (!pooled_stall) begin
			pooled_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && seg_s1.row_end) begin
			pooled_value  <= acc[SAMPLE_BITS-1:0];
			region_col    <= seg_s1.col;
			last_of_image <= seg_s1.last;
		end
	end

	// A held segment keeps its line index until it retires.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> (valid_s1 && $stable(idx_s1)))
		else $error("merge stage lost a held segment");

	// A new pooled beat comes only from a segment that closed its window.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pooled_valid) |-> $past(s1_go && seg_s1.row_end))
		else $error("pooled beat without a finished window");

	// Forwarding is flagged for every back-to-back segment pair on one entry.
	a_fwd_same: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && s1_go && idx_s1 == seg_idx) |=> fwd_s1)
		else $error("missed forward of a same-entry write");

	// No sample is taken while a result is blocked in the merge stage.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && seg_s1.row_end && pooled_valid && pooled_stall) |-> !accept)
		else $error("sample accepted over a blocked result");

endmodule
